// ----- src/pgar_pkg.sv -----
package pgar_pkg;

  // register indexes on the configuration channel
  typedef enum logic [1:0] {
    REG_CHROMA_MODE  = 2'd0,
    REG_DEEP_SAMPLES = 2'd1,
    REG_ALPHA_MODE   = 2'd2,
    REG_ALPHA_BITS   = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    CHROMA_KEEP  = 2'd0,
    CHROMA_BT601 = 2'd1,
    CHROMA_BT709 = 2'd2,
    CHROMA_SPARE = 2'd3
  } chroma_mode_t;

  typedef enum logic [1:0] {
    ALPHA_KEEP   = 2'd0,
    ALPHA_OPAQUE = 2'd1,
    ALPHA_REDUCE = 2'd2,
    ALPHA_SPARE  = 2'd3
  } alpha_mode_t;

  // what stage three does with alpha
  typedef enum logic [1:0] {
    ASEL_KEEP,
    ASEL_FULL,
    ASEL_REQ
  } alpha_sel_t;

  localparam logic [3:0] ALPHA_BITS_RST = 4'd4;

  typedef struct packed {
    logic [1:0] chroma_mode;
    logic       deep_samples;
    logic [1:0] alpha_mode;
    logic [3:0] alpha_bits;
  } cfg_t;

  // load enables of the three pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } adv_t;

  localparam logic [15:0] W601_R = 16'd19595;
  localparam logic [15:0] W601_G = 16'd38470;
  localparam logic [15:0] W601_B = 16'd7471;
  localparam logic [15:0] W709_R = 16'd13933;
  localparam logic [15:0] W709_G = 16'd46871;
  localparam logic [15:0] W709_B = 16'd4731;

  localparam logic [15:0] HALF16 = 16'd32767;
  localparam logic [15:0] FULL16 = 16'd65535;
  localparam logic [15:0] FULL8  = 16'd255;

  // floor(2^31 / (2^k - 1)), k = 1..15
  localparam logic [31:0] RECIP [16] = '{
    32'h0000_0000, 32'h8000_0000, 32'h2AAA_AAAA, 32'h1249_2492,
    32'h0888_8888, 32'h0421_0842, 32'h0208_2082, 32'h0102_0408,
    32'h0080_8080, 32'h0040_2010, 32'h0020_0802, 32'h0010_0200,
    32'h0008_0080, 32'h0004_0020, 32'h0002_0008, 32'h0001_0002
  };

endpackage

// ----- src/pgar_pix_in_if.sv -----
interface pgar_pix_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_in;
  logic [15:0] green_in;
  logic [15:0] blue_in;
  logic [15:0] alpha_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

// ----- src/pgar_pix_out_if.sv -----
interface pgar_pix_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;
  logic [15:0] alpha_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

// ----- src/pgar_cfg_if.sv -----
interface pgar_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [3:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/pixel_gray_and_alpha_requant.sv -----
// Channel   Dir  Payload                                      Handshake
// pix_in    in   red_in, green_in, blue_in, alpha_in (16 b)  valid / ready
// pix_out   out  red_out, green_out, blue_out, alpha_out     valid / ready
// cfg       in   index (2 b), data (4 b)                      valid / ready (always ready)
//
// Three register stages; one pixel per cycle sustained while pix_out is ready.
// Stage 3 is the output register; each stage loads when empty or when the
// stage after it moves, so a stalled output back-pressures without loss.
// Reset (rst, synchronous) empties the pipeline and loads register defaults.
// Luma: products, then sum and /65535 fold, then correction and saturation.
module pixel_gray_and_alpha_requant (
  input  logic        clk,
  input  logic        rst,
  pgar_cfg_if.sink    cfg,
  pgar_pix_in_if.sink pix_in,
  pgar_pix_out_if.source pix_out
);

  pgar_pkg::cfg_t cfg_q;
  pgar_pkg::adv_t adv;
  logic           v1, v2, v3;

  pgar_cfg u_cfg (
    .clk (clk),
    .rst (rst),
    .wr  (cfg),
    .cfg (cfg_q)
  );

  always_comb begin
    adv.s3 = !v3 || pix_out.ready;
    adv.s2 = !v2 || adv.s3;
    adv.s1 = !v1 || adv.s2;
  end

  assign pix_in.ready  = adv.s1;
  assign pix_out.valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv.s1) v1 <= pix_in.valid;
      if (adv.s2) v2 <= v1;
      if (adv.s3) v3 <= v2;
    end
  end

  pgar_luma u_luma (
    .clk       (clk),
    .cfg       (cfg_q),
    .adv       (adv),
    .red_in    (pix_in.red_in),
    .green_in  (pix_in.green_in),
    .blue_in   (pix_in.blue_in),
    .red_out   (pix_out.red_out),
    .green_out (pix_out.green_out),
    .blue_out  (pix_out.blue_out)
  );

  pgar_alpha u_alpha (
    .clk       (clk),
    .cfg       (cfg_q),
    .adv       (adv),
    .alpha_in  (pix_in.alpha_in),
    .alpha_out (pix_out.alpha_out)
  );

  // a bubble anywhere lets a request in
  a_bubble_ready: assert property (@(posedge clk) disable iff (rst)
    (!v1 || !v2 || !v3) |-> pix_in.ready)
    else $error("input held off with a free stage");

  a_mid_moves: assert property (@(posedge clk) disable iff (rst)
    (v2 && adv.s3) |=> v3)
    else $error("stage two item lost on advance");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (v1 && !adv.s2) |=> v1)
    else $error("stalled stage one item dropped");

  a_narrow_out: assert property (@(posedge clk) disable iff (rst)
    (v3 && !cfg_q.deep_samples) |->
      (pix_out.red_out[15:8] == 8'd0 && pix_out.green_out[15:8] == 8'd0 &&
       pix_out.blue_out[15:8] == 8'd0 && pix_out.alpha_out[15:8] == 8'd0))
    else $error("8-bit result exceeds 255");

endmodule

// ----- src/pgar_cfg.sv -----
module pgar_cfg (
  input  logic             clk,
  input  logic             rst,
  pgar_cfg_if.sink         wr,
  output pgar_pkg::cfg_t   cfg
);

  pgar_pkg::cfg_t regs;

  assign wr.ready = 1'b1;
  assign cfg      = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.chroma_mode  <= pgar_pkg::CHROMA_KEEP;
      regs.deep_samples <= 1'b0;
      regs.alpha_mode   <= pgar_pkg::ALPHA_KEEP;
      regs.alpha_bits   <= pgar_pkg::ALPHA_BITS_RST;
    end else if (wr.valid) begin
      case (wr.index)
        pgar_pkg::REG_CHROMA_MODE:  regs.chroma_mode  <= wr.data[1:0];
        pgar_pkg::REG_DEEP_SAMPLES: regs.deep_samples <= wr.data[0];
        pgar_pkg::REG_ALPHA_MODE:   regs.alpha_mode   <= wr.data[1:0];
        pgar_pkg::REG_ALPHA_BITS:   regs.alpha_bits   <= wr.data;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/pgar_luma.sv -----
module pgar_luma (
  input  logic            clk,
  input  pgar_pkg::cfg_t  cfg,
  input  pgar_pkg::adv_t  adv,
  input  logic [15:0]     red_in,
  input  logic [15:0]     green_in,
  input  logic [15:0]     blue_in,
  output logic [15:0]     red_out,
  output logic [15:0]     green_out,
  output logic [15:0]     blue_out
);

  // stage 1: masked samples and weighted products
  logic [15:0] r1, g1, b1;
  logic [31:0] pr1, pg1, pb1;
  logic        gray1, deep1;
  // stage 2: quotient estimate and remainder-ish term for /65535
  logic [15:0] r2, g2, b2;
  logic [16:0] q2;
  logic [17:0] t2;
  logic        gray2, deep2;

  logic [15:0] mask, rm, gm, bm, wr, wg, wb;
  logic [32:0] sum;
  logic [17:0] y, full;
  logic [15:0] ysat;

  always_comb begin
    mask = cfg.deep_samples ? pgar_pkg::FULL16 : pgar_pkg::FULL8;
    rm   = red_in & mask;
    gm   = green_in & mask;
    bm   = blue_in & mask;
    wr   = (cfg.chroma_mode == pgar_pkg::CHROMA_BT709) ? pgar_pkg::W709_R : pgar_pkg::W601_R;
    wg   = (cfg.chroma_mode == pgar_pkg::CHROMA_BT709) ? pgar_pkg::W709_G : pgar_pkg::W601_G;
    wb   = (cfg.chroma_mode == pgar_pkg::CHROMA_BT709) ? pgar_pkg::W709_B : pgar_pkg::W601_B;
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      r1    <= rm;
      g1    <= gm;
      b1    <= bm;
      pr1   <= rm * wr;
      pg1   <= gm * wg;
      pb1   <= bm * wb;
      gray1 <= (cfg.chroma_mode == pgar_pkg::CHROMA_BT601) ||
               (cfg.chroma_mode == pgar_pkg::CHROMA_BT709);
      deep1 <= cfg.deep_samples;
    end
  end

  // x = q*65536 + l = q*65535 + (q + l)
  assign sum = {1'b0, pr1} + {1'b0, pg1} + {1'b0, pb1} + {17'd0, pgar_pkg::HALF16};

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      r2    <= r1;
      g2    <= g1;
      b2    <= b1;
      q2    <= sum[32:16];
      t2    <= {1'b0, sum[32:16]} + {2'b0, sum[15:0]};
      gray2 <= gray1;
      deep2 <= deep1;
    end
  end

  // q + l stays below 2*65536, so at most two corrections
  always_comb begin
    if (t2 >= 18'd131070) begin
      y = {1'b0, q2} + 18'd2;
    end else if (t2 >= 18'd65535) begin
      y = {1'b0, q2} + 18'd1;
    end else begin
      y = {1'b0, q2};
    end
    full = {2'b0, deep2 ? pgar_pkg::FULL16 : pgar_pkg::FULL8};
    ysat = (y > full) ? full[15:0] : y[15:0];
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      red_out   <= gray2 ? ysat : r2;
      green_out <= gray2 ? ysat : g2;
      blue_out  <= gray2 ? ysat : b2;
    end
  end

endmodule

// ----- src/pgar_alpha.sv -----
module pgar_alpha (
  input  logic            clk,
  input  pgar_pkg::cfg_t  cfg,
  input  pgar_pkg::adv_t  adv,
  input  logic [15:0]     alpha_in,
  output logic [15:0]     alpha_out
);

  // stage 1: chopped value scaled to full range plus half divisor
  logic [15:0]          a1;
  logic [30:0]          x1;
  logic [3:0]           k1;
  logic                 deep1;
  pgar_pkg::alpha_sel_t sel1;
  // stage 2: reciprocal quotient estimate
  logic [15:0]          a2;
  logic [30:0]          x2;
  logic [16:0]          q2;
  logic [3:0]           k2;
  logic                 deep2;
  pgar_pkg::alpha_sel_t sel2;

  logic [15:0]          mask, am, cmax;
  logic [4:0]           sh;
  logic [31:0]          chop, scaled;
  logic                 width_ok;
  pgar_pkg::alpha_sel_t sel;
  logic [62:0]          prod;
  logic [15:0]          cmax2, full2, qfix;
  logic [31:0]          qc, rem;

  always_comb begin
    mask     = cfg.deep_samples ? pgar_pkg::FULL16 : pgar_pkg::FULL8;
    am       = alpha_in & mask;
    sh       = (cfg.deep_samples ? 5'd16 : 5'd8) - {1'b0, cfg.alpha_bits};
    chop     = {16'd0, am} >> sh;
    cmax     = 16'((17'd1 << cfg.alpha_bits) - 17'd1);
    // chop * (2^W - 1) as shift and subtract
    scaled   = (cfg.deep_samples ? (chop << 16) : (chop << 8)) - chop;
    width_ok = (cfg.alpha_bits != 4'd0) &&
               (cfg.deep_samples || (cfg.alpha_bits < 4'd8));
    case (cfg.alpha_mode)
      pgar_pkg::ALPHA_OPAQUE: sel = pgar_pkg::ASEL_FULL;
      pgar_pkg::ALPHA_REDUCE: sel = width_ok ? pgar_pkg::ASEL_REQ : pgar_pkg::ASEL_KEEP;
      default:                sel = pgar_pkg::ASEL_KEEP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      a1    <= am;
      x1    <= 31'(scaled + {17'd0, cmax[15:1]});
      k1    <= cfg.alpha_bits;
      deep1 <= cfg.deep_samples;
      sel1  <= sel;
    end
  end

  // estimate is floor or one below, since x < 2^31
  assign prod = x1 * pgar_pkg::RECIP[k1];

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      a2    <= a1;
      x2    <= x1;
      q2    <= prod[47:31];
      k2    <= k1;
      deep2 <= deep1;
      sel2  <= sel1;
    end
  end

  always_comb begin
    cmax2 = 16'((17'd1 << k2) - 17'd1);
    full2 = deep2 ? pgar_pkg::FULL16 : pgar_pkg::FULL8;
    qc    = ({15'd0, q2} << k2) - {15'd0, q2};
    rem   = {1'b0, x2} - qc;
    qfix  = (rem >= {16'd0, cmax2}) ? 16'(q2 + 17'd1) : q2[15:0];
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      case (sel2)
        pgar_pkg::ASEL_FULL: alpha_out <= full2;
        pgar_pkg::ASEL_REQ:  alpha_out <= qfix;
        default:             alpha_out <= a2;
      endcase
    end
  end

endmodule
